/* rtl/core/imsu_pkg.sv */
// package for the ising metropolis spin update block
// lattice geometry, register codes, shared types and the row decode
// no dependencies
`default_nettype none

package imsu_pkg;

   // lattice side length, rows and columns
   localparam int SIDE  = 64;
   localparam int SITES = SIDE * SIDE;
   localparam int ROW_W = (SIDE > 1) ? $clog2(SIDE) : 1;

   // field widths fixed by the interface
   localparam int SITE_W = 12;
   localparam int FRAC_W = 16;
   localparam int THR_W  = 17;
   localparam int MAG_W  = 14;

   // reciprocal of SIDE for the row decode, exact for every 12-bit site
   localparam int RECIP_SHIFT = 24;
   localparam longint RECIP   = (64'sd1 <<< RECIP_SHIFT) / SIDE + 1;
   localparam int PROD_W      = 40;

   // magnetization after a cold fill, low bits of +/- site count
   localparam logic [MAG_W-1:0] MAG_PLUS  = MAG_W'(SITES);
   localparam logic [MAG_W-1:0] MAG_MINUS = MAG_W'(-SITES);

   // register reset values
   localparam logic [THR_W-1:0] THR_RESET   = THR_W'(65536);
   localparam logic             START_RESET = 1'b1;

   typedef enum logic [1:0] {
      CSR_THR_FOUR   = 2'd0,
      CSR_THR_EIGHT  = 2'd1,
      CSR_START_SPIN = 2'd2
   } csr_index_type;

   typedef logic [ROW_W-1:0] row_idx_type;
   typedef logic [SIDE-1:0]  row_word_type;

   // one row write into the spin store
   typedef struct packed {
      logic         en;
      row_idx_type  row;
      row_word_type data;
   } mem_wr_type;

   // outcome of one spin update
   typedef struct packed {
      logic             flipped;
      logic             new_spin;
      logic [MAG_W-1:0] magnetization;
   } upd_type;

   // row of a site by reciprocal multiplication
   function automatic row_idx_type row_of(input logic [SITE_W-1:0] site);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(site) * PROD_W'(RECIP);
      return row_idx_type'(prod >> RECIP_SHIFT);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/imsu_row_mem.sv */
// one copy of the spin store, one lattice row per entry
// one write port, one registered read port; uses imsu_pkg
`default_nettype none

module imsu_row_mem (
   input  wire                  clock,
   input  wire                  rd_en,
   input  imsu_pkg::row_idx_type rd_row,
   input  imsu_pkg::mem_wr_type  wr,
   output imsu_pkg::row_word_type rd_data
);
   import imsu_pkg::*;

   row_word_type mem [SIDE];
   row_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/imsu_update.sv */
// metropolis decision for one site from its three lattice rows
// neighbour pick, energy class, threshold compare, row write-back; uses imsu_pkg
`default_nettype none

module imsu_update (
   input  wire [imsu_pkg::SITE_W-1:0] site,
   input  imsu_pkg::row_idx_type       row,
   input  wire                         in_range,
   input  wire [imsu_pkg::FRAC_W-1:0]  frac,
   input  imsu_pkg::row_word_type      up_word,
   input  imsu_pkg::row_word_type      cur_word,
   input  imsu_pkg::row_word_type      dn_word,
   input  wire [imsu_pkg::THR_W-1:0]   thr_four,
   input  wire [imsu_pkg::THR_W-1:0]   thr_eight,
   input  wire [imsu_pkg::MAG_W-1:0]   mag,
   input  wire                         fire,
   output imsu_pkg::upd_type           upd,
   output imsu_pkg::mem_wr_type        wr
);
   import imsu_pkg::*;

   localparam int BASE_W = 2 * ROW_W + 1;

   logic [BASE_W-1:0] base;
   row_idx_type       col;
   row_idx_type       col_l;
   row_idx_type       col_r;
   logic              spin;
   logic [3:0]        nbr;
   logic [2:0]        agree;
   logic              take;
   logic [THR_W-1:0]  frac_ext;

   // column is site minus row start
   assign base  = BASE_W'(row) * BASE_W'(SIDE);
   assign col   = row_idx_type'(BASE_W'(site) - base);
   assign col_l = (col == row_idx_type'(0)) ? row_idx_type'(SIDE - 1) : col - row_idx_type'(1);
   assign col_r = (col == row_idx_type'(SIDE - 1)) ? row_idx_type'(0) : col + row_idx_type'(1);

   assign spin = cur_word[col];
   assign nbr  = {cur_word[col_l], cur_word[col_r], up_word[col], dn_word[col]};

   // neighbours that share the spin: energy change is 4*agree - 8
   assign agree    = 3'($countones(~(nbr ^ {4{spin}})));
   assign frac_ext = THR_W'(frac);

   always_comb begin
      if (!in_range) begin
         take = 1'b0;
      end else if (agree <= 3'd2) begin
         take = 1'b1;
      end else if (agree == 3'd3) begin
         take = thr_four > frac_ext;
      end else begin
         take = thr_eight > frac_ext;
      end
   end

   always_comb begin
      upd.flipped  = take;
      upd.new_spin = in_range & (spin ^ take);
      if (!take) begin
         upd.magnetization = mag;
      end else if (spin) begin
         upd.magnetization = mag - MAG_W'(2);
      end else begin
         upd.magnetization = mag + MAG_W'(2);
      end
   end

   always_comb begin
      wr.en        = fire & take;
      wr.row       = row;
      wr.data      = cur_word;
      wr.data[col] = ~spin;
   end

endmodule

`default_nettype wire

/* rtl/core/ising_metropolis_spin_update.sv */
// top level of the ising metropolis spin update block
// csr port, input stage, three row stores, result register; uses imsu_pkg,
// imsu_row_mem and imsu_update
`default_nettype none

//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+----------------------------------
//  req      | in        | req_valid / req_stall  | site, random_fraction
//  rsp      | out       | rsp_valid / rsp_stall  | flipped, new_spin, magnetization
//  csr      | in        | apb, pready tied high  | thresholds four and eight, start spin
//
// one word a cycle unless rsp_stall; the input stage feeds the result register
// the row decode sits in front of three row-store copies read at acceptance; the
// decision and write-back of the row run from those registered rows
// reset and a start spin write mark every row unwritten, so rows read as the start
// spin at once with no clearing pass
// a stalled result holds in the output register while one more word waits in the
// input stage; input stall rises only when both are full

module ising_metropolis_spin_update (
   input  wire                        clock,
   input  wire                        reset,
   // request channel
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire [imsu_pkg::SITE_W-1:0] req_site,
   input  wire [imsu_pkg::FRAC_W-1:0] req_random_fraction,
   // result channel
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic                       rsp_flipped,
   output logic                       rsp_new_spin,
   output logic [imsu_pkg::MAG_W-1:0] rsp_magnetization,
   // register port
   input  wire                        csr_psel,
   input  wire                        csr_penable,
   input  wire                        csr_pwrite,
   input  wire [3:0]                  csr_paddr,
   input  wire [31:0]                 csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import imsu_pkg::*;

   // configuration registers
   logic [THR_W-1:0] thr_four_ff, thr_four_in;
   logic [THR_W-1:0] thr_eight_ff, thr_eight_in;
   logic             start_ff, start_in;
   csr_index_type    csr_index;
   logic             csr_wr;
   logic             start_wr;

   // input stage
   logic              stg_valid_ff, stg_valid_in;
   logic [SITE_W-1:0] stg_site_ff;
   logic [FRAC_W-1:0] stg_frac_ff;
   logic              stg_in_range_ff;
   row_idx_type       stg_row_ff;
   row_idx_type       stg_up_ff;
   row_idx_type       stg_dn_ff;

   // accept side row decode
   logic        accept;
   logic        advance;
   logic        acc_in_range;
   row_idx_type acc_row;
   row_idx_type acc_up;
   row_idx_type acc_dn;

   // spin store state
   row_word_type row_valid_ff, row_valid_in;
   logic         wr_valid_ff, wr_valid_in;
   row_idx_type  wr_row_ff;
   row_word_type wr_data_ff;
   logic [MAG_W-1:0] mag_ff, mag_in;

   row_word_type up_raw, cur_raw, dn_raw;
   row_word_type up_word, cur_word, dn_word;
   mem_wr_type   wr;
   upd_type      upd;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   upd_type rsp_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign start_wr   = csr_wr && (csr_index == CSR_START_SPIN);

   always_comb begin
      thr_four_in  = thr_four_ff;
      thr_eight_in = thr_eight_ff;
      start_in     = start_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_THR_FOUR: begin
               thr_four_in = csr_pwdata[THR_W-1:0];
            end
            CSR_THR_EIGHT: begin
               thr_eight_in = csr_pwdata[THR_W-1:0];
            end
            CSR_START_SPIN: begin
               start_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_THR_FOUR:   csr_prdata = 32'(thr_four_ff);
         CSR_THR_EIGHT:  csr_prdata = 32'(thr_eight_ff);
         CSR_START_SPIN: csr_prdata = 32'(start_ff);
         default:        csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // the input stage moves on when the result register is free or being taken
   assign advance   = stg_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = stg_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------- row decode
   // sites past the lattice touch row zero and change nothing
   assign acc_in_range = 32'(req_site) < SITES;
   assign acc_row = acc_in_range ? row_of(req_site) : row_idx_type'(0);
   assign acc_up  = (acc_row == row_idx_type'(0)) ? row_idx_type'(SIDE - 1)
                                                  : acc_row - row_idx_type'(1);
   assign acc_dn  = (acc_row == row_idx_type'(SIDE - 1)) ? row_idx_type'(0)
                                                         : acc_row + row_idx_type'(1);

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_site_ff     <= req_site;
         stg_frac_ff     <= req_random_fraction;
         stg_in_range_ff <= acc_in_range;
         stg_row_ff      <= acc_row;
         stg_up_ff       <= acc_up;
         stg_dn_ff       <= acc_dn;
      end
   end

   // ---------------------------------------------------------------- spin store
   // three copies, all written alike, each read at one of the three rows
   imsu_row_mem u_mem_up (
      .clock   (clock),
      .rd_en   (accept),
      .rd_row  (acc_up),
      .wr      (wr),
      .rd_data (up_raw)
   );

   imsu_row_mem u_mem_cur (
      .clock   (clock),
      .rd_en   (accept),
      .rd_row  (acc_row),
      .wr      (wr),
      .rd_data (cur_raw)
   );

   imsu_row_mem u_mem_dn (
      .clock   (clock),
      .rd_en   (accept),
      .rd_row  (acc_dn),
      .wr      (wr),
      .rd_data (dn_raw)
   );

   // the last row written is always current, so it overrides a read that may have
   // raced it; an unwritten row reads as the start spin
   function automatic row_word_type fix_word(
      input row_idx_type  row,
      input row_word_type raw,
      input logic         byp_valid,
      input row_idx_type  byp_row,
      input row_word_type byp_data,
      input row_word_type valid_bits,
      input logic         fill
   );
      row_word_type res;
      if (byp_valid && (byp_row == row)) begin
         res = byp_data;
      end else if (valid_bits[row]) begin
         res = raw;
      end else begin
         res = {SIDE{fill}};
      end
      return res;
   endfunction

   assign up_word  = fix_word(stg_up_ff, up_raw, wr_valid_ff, wr_row_ff, wr_data_ff,
                              row_valid_ff, start_ff);
   assign cur_word = fix_word(stg_row_ff, cur_raw, wr_valid_ff, wr_row_ff, wr_data_ff,
                              row_valid_ff, start_ff);
   assign dn_word  = fix_word(stg_dn_ff, dn_raw, wr_valid_ff, wr_row_ff, wr_data_ff,
                              row_valid_ff, start_ff);

   imsu_update u_update (
      .site      (stg_site_ff),
      .row       (stg_row_ff),
      .in_range  (stg_in_range_ff),
      .frac      (stg_frac_ff),
      .up_word   (up_word),
      .cur_word  (cur_word),
      .dn_word   (dn_word),
      .thr_four  (thr_four_ff),
      .thr_eight (thr_eight_ff),
      .mag       (mag_ff),
      .fire      (advance),
      .upd       (upd),
      .wr        (wr)
   );

   // cold restart on a start spin write, otherwise track each flip
   always_comb begin
      row_valid_in = row_valid_ff;
      wr_valid_in  = wr_valid_ff;
      mag_in       = mag_ff;
      if (start_wr) begin
         row_valid_in = '0;
         wr_valid_in  = 1'b0;
         mag_in       = csr_pwdata[0] ? MAG_PLUS : MAG_MINUS;
      end else begin
         if (wr.en) begin
            row_valid_in[wr.row] = 1'b1;
            wr_valid_in          = 1'b1;
         end
         if (advance) begin
            mag_in = upd.magnetization;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_four_ff  <= THR_RESET;
         thr_eight_ff <= THR_RESET;
         start_ff     <= START_RESET;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         wr_valid_ff  <= 1'b0;
         mag_ff       <= START_RESET ? MAG_PLUS : MAG_MINUS;
      end else begin
         thr_four_ff  <= thr_four_in;
         thr_eight_ff <= thr_eight_in;
         start_ff     <= start_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         wr_valid_ff  <= wr_valid_in;
         mag_ff       <= mag_in;
      end
   end

   // bypass copy of the last row write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         wr_row_ff  <= wr.row;
         wr_data_ff <= wr.data;
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= upd;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flipped       = rsp_ff.flipped;
   assign rsp_new_spin      = rsp_ff.new_spin;
   assign rsp_magnetization = rsp_ff.magnetization;

   // ---------------------------------------------------------------- checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stg_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room downstream");

   a_mag_moves_on_flip: assert property (@(posedge clock) disable iff (reset)
      (advance && upd.flipped && !start_wr) |=>
         (mag_ff == $past(mag_ff) + MAG_W'(2) || mag_ff == $past(mag_ff) - MAG_W'(2)))
      else $error("magnetization did not move by two on a flip");

   a_mag_still: assert property (@(posedge clock) disable iff (reset)
      (!(advance && upd.flipped) && !start_wr) |=> $stable(mag_ff))
      else $error("magnetization changed without a flip");

   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      (wr.en && !start_wr) |=> (row_valid_ff[$past(wr.row)] && wr_valid_ff))
      else $error("written row not marked valid");

endmodule

`default_nettype wire
